FILE: rtl/rhpm_pkg.sv
// Shared types, constants and modular helpers for the rolling hash pattern matcher.
// Has no dependencies; every other file in rtl except rhpm_fifo refers to it by scoped names.
package rhpm_pkg;

  localparam int MAX_PATTERN_DEF   = 64;
  localparam int POSITION_BITS_DEF = 32;

  localparam int HASH_W = 30;
  localparam logic [HASH_W-1:0] HASH_MOD    = 30'd1000000009;
  localparam logic [HASH_W-1:0] HASH_ONE    = 30'd1;
  localparam logic [7:0]        CHAR_OFFSET = 8'd96;

  // 2^30 is congruent to FOLD modulo HASH_MOD, which lets high bits fold back down.
  localparam logic [31:0] FOLD = 32'd1073741824 - 32'(HASH_MOD);

  // Barrett reciprocal for products below 2^60.
  localparam logic [63:0] MU_WIDE = (64'd1 << 60) / 64'(HASH_MOD);
  localparam logic [30:0] MU      = MU_WIDE[30:0];

  // Register stages inside the modular multiplier.
  localparam int MODMUL_LAT = 4;

  // Entries of the result queue; also the credit limit on text items in flight.
  localparam int OUT_DEPTH = 16;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_TEXT    = 2'd2
  } kind_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  function automatic logic [HASH_W-1:0] byte_value(input logic [7:0] ch);
    logic [HASH_W-1:0] v;
    if (ch >= CHAR_OFFSET) begin
      v = 30'(ch) - 30'(CHAR_OFFSET);
    end else begin
      v = 30'(ch) + (HASH_MOD - 30'(CHAR_OFFSET));
    end
    return v;
  endfunction

  function automatic logic [HASH_W-1:0] add_mod(input logic [HASH_W-1:0] a,
                                               input logic [HASH_W-1:0] b);
    logic [HASH_W:0] s;
    s = 31'(a) + 31'(b);
    if (s >= 31'(HASH_MOD)) begin
      s = s - 31'(HASH_MOD);
    end
    return s[HASH_W-1:0];
  endfunction

  // p * 31 mod HASH_MOD by two folds of the bits above 2^30 and one correction.
  function automatic logic [HASH_W-1:0] mul_base_mod(input logic [HASH_W-1:0] p);
    logic [34:0] x;
    logic [31:0] r1;
    logic [30:0] r2;
    x  = {p, 5'b0} - 35'(p);
    r1 = 32'(x[29:0]) + 32'(x[34:30]) * FOLD;
    r2 = 31'(r1[29:0]) + 31'(r1[31:30]) * 31'(FOLD);
    if (r2 >= 31'(HASH_MOD)) begin
      r2 = r2 - 31'(HASH_MOD);
    end
    return r2[HASH_W-1:0];
  endfunction

endpackage

FILE: rtl/rhpm_cell.sv
// One cell of the window delay line: holds one stored hash target.
// Depends on rhpm_pkg for the hash width and the cell control struct.
module rhpm_cell (
  input  logic                          clk,
  input  rhpm_pkg::cell_ctl_t           ctl,
  input  logic [rhpm_pkg::HASH_W-1:0]   x_in,
  input  logic [rhpm_pkg::HASH_W-1:0]   nxt,
  output logic [rhpm_pkg::HASH_W-1:0]   val
);

  // The cell at the tail of the active window takes the new value; the others
  // take their neighbour's.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      val <= ctl.load ? x_in : nxt;
    end
  end

endmodule

FILE: rtl/rhpm_modmul.sv
// Pipelined multiplier modulo the hash prime, Barrett reduction over four stages.
// Depends on rhpm_pkg for the modulus, the reciprocal and the hash width.
module rhpm_modmul (
  input  logic                          clk,
  input  logic [rhpm_pkg::HASH_W-1:0]   a,
  input  logic [rhpm_pkg::HASH_W-1:0]   b,
  output logic [rhpm_pkg::HASH_W-1:0]   r
);

  logic [59:0] prod;
  logic [29:0] quot;
  logic [31:0] prod_lo;
  logic [31:0] rem;

  logic [61:0] quot_wide;
  logic [59:0] qm;

  assign quot_wide = 62'(prod[59:29]) * 62'(rhpm_pkg::MU);
  assign qm        = 60'(quot) * 60'(rhpm_pkg::HASH_MOD);

  always_ff @(posedge clk) begin
    prod    <= 60'(a) * 60'(b);
    // The estimate is at most two below the true quotient.
    quot    <= quot_wide[60:31];
    prod_lo <= prod[31:0];
    rem     <= prod_lo - qm[31:0];
    if (rem >= 32'(rhpm_pkg::HASH_MOD) * 32'd2) begin
      r <= 30'(rem - 32'(rhpm_pkg::HASH_MOD) * 32'd2);
    end else if (rem >= 32'(rhpm_pkg::HASH_MOD)) begin
      r <= 30'(rem - 32'(rhpm_pkg::HASH_MOD));
    end else begin
      r <= rem[29:0];
    end
  end

endmodule

FILE: rtl/rhpm_fifo.sv
// Small register queue that holds match positions until the consumer takes them.
// Depends on nothing beyond its parameters.
module rhpm_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign not_empty = (count != '0);
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/rolling_hash_pattern_matcher.sv
// Top level of the rolling hash pattern matcher: front end, hash pipeline, cell row.
// Depends on rhpm_pkg, rhpm_modmul, rhpm_cell and rhpm_fifo.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------
//   input    | in_valid / in_ready  | kind [1:0], ch [7:0]
//   output   | out_valid / out_ready| match_position [31:0]
//
// One item is taken per cycle while in_ready is high. On its way to the result queue
// a text byte's result passes two four-stage modular multipliers, an accumulate stage
// and the compare against the cell row. in_ready falls only while text items in flight
// plus queued results reach the 16-entry result queue. Reset is synchronous; the cell
// row needs no clearing. Output stalls never stall the pipeline itself.
module rolling_hash_pattern_matcher #(
  parameter int MAX_PATTERN   = rhpm_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = rhpm_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] match_position
);

  localparam int HW    = rhpm_pkg::HASH_W;
  localparam int LAT   = rhpm_pkg::MODMUL_LAT;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W = ((POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W) + 1;
  localparam int CRW   = $clog2(rhpm_pkg::OUT_DEPTH + 1);

  typedef struct packed {
    logic [1:0]               kind;
    logic [HW-1:0]            v;
    logic [HW-1:0]            pow;
    logic                     add;
    logic [LEN_W-1:0]         len;
    logic                     cmp_en;
    logic [POSITION_BITS-1:0] pos;
  } tok_t;

  // Front-end state.
  logic [HW-1:0]            pattern_power;
  logic [LEN_W-1:0]         pattern_length;
  logic [HW-1:0]            text_power;
  logic [POSITION_BITS-1:0] text_count;
  logic [CRW-1:0]           credit;

  logic accept;
  logic text_in;
  logic [CMP_W-1:0] count_inc;
  logic [CMP_W-1:0] len_ext;
  logic             count_sat;

  assign in_ready  = (credit < CRW'(rhpm_pkg::OUT_DEPTH));
  assign accept    = in_valid && in_ready;
  assign text_in   = accept && (kind == rhpm_pkg::KIND_TEXT);
  assign count_sat = &text_count;
  assign count_inc = CMP_W'(text_count) + CMP_W'(1);
  assign len_ext   = CMP_W'(pattern_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_power  <= rhpm_pkg::HASH_ONE;
      pattern_length <= '0;
      text_power     <= rhpm_pkg::HASH_ONE;
      text_count     <= '0;
    end else if (accept) begin
      case (kind)
        rhpm_pkg::KIND_CLEAR: begin
          pattern_power  <= rhpm_pkg::HASH_ONE;
          pattern_length <= '0;
          text_power     <= rhpm_pkg::HASH_ONE;
          text_count     <= '0;
        end
        rhpm_pkg::KIND_PATTERN: begin
          if (pattern_length < LEN_W'(MAX_PATTERN)) begin
            pattern_power  <= rhpm_pkg::mul_base_mod(pattern_power);
            pattern_length <= pattern_length + LEN_W'(1);
          end
          text_power <= rhpm_pkg::HASH_ONE;
          text_count <= '0;
        end
        rhpm_pkg::KIND_TEXT: begin
          text_power <= rhpm_pkg::mul_base_mod(text_power);
          if (!count_sat) begin
            text_count <= text_count + POSITION_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Stage 0: the item as it enters the hash pipeline.
  tok_t tok0;
  logic v0;

  always_ff @(posedge clk) begin
    tok0.kind   <= kind;
    tok0.v      <= rhpm_pkg::byte_value(ch);
    tok0.pow    <= (kind == rhpm_pkg::KIND_PATTERN) ? pattern_power : text_power;
    tok0.add    <= (pattern_length < LEN_W'(MAX_PATTERN));
    tok0.len    <= pattern_length;
    tok0.cmp_en <= (pattern_length != '0) && (count_sat || (count_inc >= len_ext));
    tok0.pos    <= count_sat ? text_count : POSITION_BITS'(count_inc - len_ext);
  end

  // Term of the hash: byte value times its power.
  logic [HW-1:0] term;
  tok_t tok_a [LAT];
  logic [LAT-1:0] va;

  rhpm_modmul u_term_mul (
    .clk (clk),
    .a   (tok0.v),
    .b   (tok0.pow),
    .r   (term)
  );

  always_ff @(posedge clk) begin
    tok_a[0] <= tok0;
    for (int k = 1; k < LAT; k++) begin
      tok_a[k] <= tok_a[k-1];
    end
  end

  // Accumulate stage: pattern hash and text prefix hash.
  logic [HW-1:0] pattern_hash;
  logic [HW-1:0] text_prefix_hash;
  tok_t          tok5;
  logic          v5;
  logic [HW-1:0] hold5;
  logic [HW-1:0] hnew5;
  tok_t          tok_acc;

  assign tok_acc = tok_a[LAT-1];

  always_ff @(posedge clk) begin
    tok5  <= tok_acc;
    hold5 <= text_prefix_hash;
    hnew5 <= rhpm_pkg::add_mod(text_prefix_hash, term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_hash     <= '0;
      text_prefix_hash <= '0;
    end else if (va[LAT-1]) begin
      case (tok_acc.kind)
        rhpm_pkg::KIND_CLEAR: begin
          pattern_hash     <= '0;
          text_prefix_hash <= '0;
        end
        rhpm_pkg::KIND_PATTERN: begin
          if (tok_acc.add) begin
            pattern_hash <= rhpm_pkg::add_mod(pattern_hash, term);
          end
          text_prefix_hash <= '0;
        end
        rhpm_pkg::KIND_TEXT: begin
          text_prefix_hash <= rhpm_pkg::add_mod(text_prefix_hash, term);
        end
        default: begin
        end
      endcase
    end
  end

  // Pattern hash scaled to the power at this byte. The pattern hash register is
  // already up to date for the item in stage five, since pattern bytes pass first.
  logic [HW-1:0] scaled;
  tok_t          tok_b  [LAT];
  logic [HW-1:0] hold_b [LAT];
  logic [HW-1:0] hnew_b [LAT];
  logic [LAT-1:0] vb;

  rhpm_modmul u_scale_mul (
    .clk (clk),
    .a   (pattern_hash),
    .b   (tok5.pow),
    .r   (scaled)
  );

  always_ff @(posedge clk) begin
    tok_b[0]  <= tok5;
    hold_b[0] <= hold5;
    hnew_b[0] <= hnew5;
    for (int k = 1; k < LAT; k++) begin
      tok_b[k]  <= tok_b[k-1];
      hold_b[k] <= hold_b[k-1];
      hnew_b[k] <= hnew_b[k-1];
    end
  end

  // Target that the prefix hash must reach once a window started here is complete.
  tok_t          tok10;
  logic          v10;
  logic [HW-1:0] x10;
  logic [HW-1:0] hnew10;

  always_ff @(posedge clk) begin
    tok10  <= tok_b[LAT-1];
    x10    <= rhpm_pkg::add_mod(hold_b[LAT-1], scaled);
    hnew10 <= hnew_b[LAT-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      va  <= '0;
      v5  <= 1'b0;
      vb  <= '0;
      v10 <= 1'b0;
    end else begin
      v0  <= accept;
      va  <= {va[LAT-2:0], v0};
      v5  <= va[LAT-1];
      vb  <= {vb[LAT-2:0], v5};
      v10 <= vb[LAT-1];
    end
  end

  // Row of cells: cell j holds the target of the byte that starts the window
  // ending j bytes from now. New targets enter at the cell for the pattern length.
  logic [HW-1:0] chain_val [MAX_PATTERN + 1];
  logic          shift;
  logic          is_text10;

  assign is_text10              = v10 && (tok10.kind == rhpm_pkg::KIND_TEXT);
  assign shift                  = is_text10;
  assign chain_val[MAX_PATTERN] = x10;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    rhpm_pkg::cell_ctl_t ctl;
    assign ctl.shift = shift;
    assign ctl.load  = (tok10.len == LEN_W'(i + 1));
    rhpm_cell u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .x_in (x10),
      .nxt  (chain_val[i+1]),
      .val  (chain_val[i])
    );
  end

  logic [HW-1:0] window_target;
  logic          hit;
  logic          pop;
  logic [63:0]   pos_wide;

  assign window_target = (tok10.len == LEN_W'(1)) ? x10 : chain_val[1];
  assign hit           = is_text10 && tok10.cmp_en && (window_target == hnew10);
  assign pos_wide      = 64'(tok10.pos);
  assign pop           = out_valid && out_ready;

  rhpm_fifo #(
    .WIDTH (32),
    .DEPTH (rhpm_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (hit),
    .wdata     (pos_wide[31:0]),
    .pop       (pop),
    .not_empty (out_valid),
    .rdata     (match_position)
  );

  // A credit is held by each text item from its transfer until it either leaves
  // without a match or its result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + CRW'(text_in) - CRW'(is_text10 && !hit) - CRW'(pop);
    end
  end

endmodule

FILE: rtl/rhpm_checker.sv
// Port-level checks for the rolling hash pattern matcher, bound to its top level.
// Depends on rhpm_pkg for the item kind codes.
module rhpm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] match_position
);

  logic text_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_seen <= 1'b0;
    end else if (in_valid && in_ready && (kind == rhpm_pkg::KIND_TEXT)) begin
      text_seen <= 1'b1;
    end
  end

  // Reset empties the result queue and returns every credit.
  a_reset_state: assert property (@(posedge clk) rst |=> (!out_valid && in_ready))
    else $error("state after reset is not empty and ready");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(match_position)))
    else $error("stalled result changed or vanished");

  // A result can only come from a text byte taken since reset.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !text_seen |-> !out_valid)
    else $error("result without any text transfer");

  // With the queue empty, the text items in flight never use up all credits.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while no result is waiting");

endmodule

bind rolling_hash_pattern_matcher rhpm_checker u_rhpm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .kind           (kind),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .match_position (match_position)
);

FILE: test/tb.sv
`timescale 1ns / 1ps
// Testbench for rolling_hash_pattern_matcher: directed cases and random streams of pattern
// and text bytes, with a local rolling-hash predictor checking every match position.
// Depends on rhpm_pkg and the matcher RTL; needs no other files.
module tb;

  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int          RING_DEPTH  = rhpm_pkg::MAX_PATTERN_DEF;
  localparam logic [63:0] MODULUS     = 64'd1000000009;
  localparam logic [63:0] BASE        = 64'd31;
  localparam logic [63:0] VALUE_SHIFT = 64'd96;
  localparam logic [31:0] POS_LIMIT   = 32'hFFFF_FFFF;
  localparam int          QUIET_LIMIT = 5000;
  localparam int          TAIL_CYCLES = 40;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [7:0]  ch;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] match_position;

  rolling_hash_pattern_matcher u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .ch             (ch),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .match_position (match_position)
  );

  // Predictor state at the widths of the block.
  logic [29:0] pat_hash;
  logic [29:0] pat_pow;
  logic [6:0]  pat_len;
  logic [29:0] txt_hash;
  logic [29:0] txt_pow;
  logic [31:0] txt_count;
  int          ring_wr;
  logic [29:0] prefix_ring [RING_DEPTH];
  logic [29:0] power_ring  [RING_DEPTH];

  logic [31:0] pending_positions [$];
  logic [7:0]  motif [$];

  int error_count;
  int sent_items;
  int send_idle_pct;
  int stall_pct;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [29:0] byte_weight(input logic [7:0] c);
    if (64'(c) >= VALUE_SHIFT) begin
      return 30'(64'(c) - VALUE_SHIFT);
    end
    return 30'(64'(c) + MODULUS - VALUE_SHIFT);
  endfunction

  function automatic logic [29:0] times_mod(input logic [29:0] a, input logic [29:0] b);
    return 30'((64'(a) * 64'(b)) % MODULUS);
  endfunction

  function automatic logic [29:0] plus_mod(input logic [29:0] a, input logic [29:0] b);
    return 30'((64'(a) + 64'(b)) % MODULUS);
  endfunction

  task automatic clear_hashes();
    pat_hash = '0;
    pat_pow  = 30'd1;
    pat_len  = '0;
    txt_hash = '0;
    txt_pow  = 30'd1;
    txt_count = '0;
    ring_wr  = 0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      prefix_ring[i] = '0;
      power_ring[i]  = '0;
    end
  endtask

  // Advances the hashes by one accepted byte and queues the match position it causes.
  task automatic advance_hashes(input logic [1:0] k, input logic [7:0] c);
    logic [29:0] v;
    logic [31:0] prior_count;
    logic [29:0] window;
    logic [29:0] wanted;
    int          slot;
    int          start;
    v = byte_weight(c);
    case (k)
      rhpm_pkg::KIND_CLEAR: begin
        clear_hashes();
      end
      rhpm_pkg::KIND_PATTERN: begin
        if (int'(pat_len) < RING_DEPTH) begin
          pat_hash = plus_mod(pat_hash, times_mod(v, pat_pow));
          pat_pow  = times_mod(pat_pow, 30'(BASE));
          pat_len  = pat_len + 7'd1;
        end
        txt_hash  = '0;
        txt_pow   = 30'd1;
        txt_count = '0;
        ring_wr   = 0;
      end
      rhpm_pkg::KIND_TEXT: begin
        prior_count = txt_count;
        slot   = ring_wr;
        prefix_ring[slot] = txt_hash;
        power_ring[slot]  = txt_pow;
        txt_hash = plus_mod(txt_hash, times_mod(v, txt_pow));
        txt_pow  = times_mod(txt_pow, 30'(BASE));
        if (txt_count != POS_LIMIT) begin
          txt_count = txt_count + 32'd1;
        end
        ring_wr = (slot + 1) % RING_DEPTH;
        if (pat_len != '0 &&
            (prior_count == POS_LIMIT || 33'(prior_count) + 33'd1 >= 33'(pat_len))) begin
          start  = (slot - (int'(pat_len) - 1) + RING_DEPTH) % RING_DEPTH;
          window = 30'((64'(txt_hash) + MODULUS - 64'(prefix_ring[start])) % MODULUS);
          wanted = times_mod(pat_hash, power_ring[start]);
          if (window == wanted) begin
            if (prior_count == POS_LIMIT) begin
              pending_positions = {pending_positions, POS_LIMIT};
            end else begin
              pending_positions = {pending_positions,
                                   prior_count + 32'd1 - 32'(pat_len)};
            end
          end
        end
      end
      default: begin
        // The unused kind leaves everything as it was.
      end
    endcase
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] wanted);
    $display("MISMATCH at %0t: %s, got %0d, expected %0d", $time, what, got, wanted);
    error_count++;
  endtask

  // Offers one byte, holding it until the transfer, then tracks it in the predictor.
  task automatic send_item(input logic [1:0] k, input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    ch       <= c;
    do @(posedge clk); while (!in_ready);
    advance_hashes(k, c);
    if (k == rhpm_pkg::KIND_CLEAR) begin
      motif.delete();
    end else if (k == rhpm_pkg::KIND_PATTERN && motif.size() < RING_DEPTH) begin
      motif = {motif, c};
    end
    if (k != KIND_UNUSED) begin
      sent_items++;
    end
  endtask

  function automatic logic [7:0] pick_byte(input logic [7:0] base, input bit narrow);
    if (narrow) begin
      return base + 8'($urandom_range(1));
    end
    return 8'($urandom_range(255));
  endfunction

  // One stretch of traffic: mostly a pattern followed by text seeded with copies of it.
  task automatic send_sequence();
    logic [7:0] base;
    bit         narrow;
    int         plen;
    int         tlen;
    int         count;
    base   = 8'($urandom_range(255));
    narrow = ($urandom_range(3) != 0);
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 4)) begin
        send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
      return;
    end
    if ($urandom_range(99) < 70 || motif.size() == 0) begin
      send_item(rhpm_pkg::KIND_CLEAR, 8'($urandom_range(255)));
      plen = ($urandom_range(99) < 8) ? $urandom_range(40, 70) : $urandom_range(1, 6);
    end else begin
      plen = $urandom_range(1) ? $urandom_range(1, 3) : 0;
    end
    repeat (plen) begin
      send_item(rhpm_pkg::KIND_PATTERN, pick_byte(base, narrow));
    end
    tlen  = 2 * motif.size() + $urandom_range(8, 40);
    count = 0;
    while (count < tlen) begin
      if ($urandom_range(99) < 4) begin
        // A stray pattern byte breaks the run and restarts the text.
        send_item(rhpm_pkg::KIND_PATTERN, pick_byte(base, narrow));
        count++;
      end else if ($urandom_range(1) && motif.size() > 0) begin
        foreach (motif[i]) begin
          send_item(rhpm_pkg::KIND_TEXT, motif[i]);
        end
        count += motif.size();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(rhpm_pkg::KIND_TEXT, pick_byte(base, narrow));
          count++;
        end
      end
    end
  endtask

  task automatic run_traffic(input int items, input int idle_pct, input int stall);
    int target;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    target        = sent_items + items;
    while (sent_items < target) begin
      send_sequence();
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_item(KIND_UNUSED, 8'hFF);
    // No pattern yet, so text never matches.
    send_item(rhpm_pkg::KIND_TEXT, 8'h00);
    send_item(rhpm_pkg::KIND_TEXT, 8'hFF);
    send_item(rhpm_pkg::KIND_PATTERN, 8'h61);
    send_item(rhpm_pkg::KIND_PATTERN, 8'h62);
    send_item(KIND_UNUSED, 8'h00);
    send_item(rhpm_pkg::KIND_TEXT, 8'h61);
    send_item(rhpm_pkg::KIND_TEXT, 8'h62);
    send_item(rhpm_pkg::KIND_TEXT, 8'h61);
    send_item(rhpm_pkg::KIND_TEXT, 8'h62);
    // A pattern byte lengthens the pattern and restarts the text count.
    send_item(rhpm_pkg::KIND_PATTERN, 8'h00);
    send_item(rhpm_pkg::KIND_TEXT, 8'h61);
    send_item(rhpm_pkg::KIND_TEXT, 8'h62);
    send_item(rhpm_pkg::KIND_TEXT, 8'h00);
    send_item(rhpm_pkg::KIND_CLEAR, 8'h00);
    send_item(rhpm_pkg::KIND_PATTERN, 8'h5F);
    send_item(rhpm_pkg::KIND_TEXT, 8'h5F);
    send_item(rhpm_pkg::KIND_TEXT, 8'h60);
    send_item(rhpm_pkg::KIND_CLEAR, 8'hFF);
    send_item(rhpm_pkg::KIND_PATTERN, 8'h60);
    send_item(rhpm_pkg::KIND_TEXT, 8'h60);
    send_item(rhpm_pkg::KIND_TEXT, 8'h80);
    send_item(rhpm_pkg::KIND_TEXT, 8'hFF);
  endtask

  task automatic test_no_idling();
    run_traffic(450, 0, 0);
  endtask

  task automatic test_sender_idle();
    run_traffic(440, 77, 0);
  endtask

  task automatic test_receiver_stall();
    run_traffic(440, 0, 77);
  endtask

  task automatic test_both_idle();
    run_traffic(450, 15, 15);
  endtask

  task automatic finish_run();
    int waited;
    in_valid <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    waited = 0;
    while (pending_positions.size() != 0 && waited < QUIET_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    foreach (pending_positions[i]) begin
      flag_mismatch("match never produced", 32'd0, pending_positions[i]);
    end
  endtask

  // Result side: random back-pressure and a check of every transfer.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (pending_positions.size() == 0) begin
        flag_mismatch("unexpected match_position", match_position, 32'd0);
      end else begin
        if (match_position !== pending_positions[0]) begin
          flag_mismatch("match_position", match_position, pending_positions[0]);
        end
        void'(pending_positions.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    kind          = rhpm_pkg::KIND_CLEAR;
    ch            = 8'd0;
    error_count   = 0;
    sent_items    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    clear_hashes();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    finish_run();
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

FILE: rolling_hash_pattern_matcher.f
rtl/rhpm_pkg.sv
rtl/rhpm_cell.sv
rtl/rhpm_modmul.sv
rtl/rhpm_fifo.sv
rtl/rolling_hash_pattern_matcher.sv
rtl/rhpm_checker.sv
test/tb.sv
